// ----- rtl/stack_machine_token_executor_defines.svh -----
// Assertion macros used by the checker file of the token executor.
// No dependencies; included by bare file name.
`ifndef STACK_MACHINE_TOKEN_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_TOKEN_EXECUTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMTE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SMTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smte_pkg.sv -----
// Shared types and constants of the stack-machine token executor.
// No dependencies.
package smte_pkg;

    localparam int MODE_W    = 4;
    localparam int OPERAND_W = 64;
    localparam int TOP_W     = 64;
    localparam int DEPTH_W   = 11;
    localparam int NEXT_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 96;

    localparam logic [MODE_W-1:0] MODE_PUSH = 4'd1;
    localparam logic [MODE_W-1:0] MODE_ADD  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SUB  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MUL  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DIV  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_JUMP = 4'd6;
    localparam logic [MODE_W-1:0] MODE_CMP  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_JEQ  = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic                load_in;
        logic                rd_second;
        logic                rd_third;
        logic                do_push;
        logic                do_cmp;
        logic                do_jump;
        logic                do_adv;
        logic                do_wr_r;
        logic                md_start;
        logic                do_pop2;
        logic                load_third;
        logic                load_out;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              cnt_ge1;
        logic              cnt_ge2;
        logic              cnt_ge3;
        logic              full;
        logic              b_zero;
        logic              eq_ab;
        logic              md_done;
    } sts_t;

endpackage

// ----- rtl/stack_machine_token_executor.sv -----
// Channel   Dir  Ports                               Fields (low bit first)
// s_        in   s_tvalid s_tready s_tdata[71:0]     mode[3:0] operand[67:4]
// m_        out  m_tvalid m_tready m_tdata[95:0]     top_value depth next_index status
//
// One token at a time. Push, jump, compare and errors found at decode go from S_DECODE
// to S_DONE; add/sub and divide by zero also pass S_READ; jump-if-equal passes S_READ and,
// when the new top must be read from stack RAM, S_READ3; mul/div wait in S_MD for the unit.
// A result waits in the output register; the next item is taken once it is loaded.
// Synchronous active-low reset empties the stack and zeroes the program index.
// Top level: controller, datapath. Depends on smte_pkg.
module stack_machine_token_executor
    import smte_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int DATA_WIDTH  = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[3:0], operand[67:4], pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // top_value[63:0], depth[74:64],
                                            // next_index[90:75], status[93:91], pad
);

    cmd_t cmd;
    sts_t sts;

    smte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smte_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

// ----- rtl/smte_ram.sv -----
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module smte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/smte_muldiv.sv -----
// Shared bit-serial multiply / signed truncating divide, one bit per cycle.
// No package dependencies.
module smte_muldiv #(
    parameter int DW = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          is_div,
    input  logic [DW-1:0] a,
    input  logic [DW-1:0] b,
    output logic          done,
    output logic [DW-1:0] result
);

    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [DW-1:0]    acc_reg, acc_next;
    logic [DW-1:0]    x_reg, x_next;
    logic [DW-1:0]    y_reg, y_next;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_diff;
    logic [DW-1:0]    abs_a, abs_b;

    assign abs_a    = a[DW-1] ? (~a + 1'b1) : a;
    assign abs_b    = b[DW-1] ? (~b + 1'b1) : b;
    assign rem_sh   = {acc_reg, x_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, y_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = is_div;
            neg_next  = a[DW-1] ^ b[DW-1];
            acc_next  = '0;
            x_next    = is_div ? abs_a : a;
            y_next    = is_div ? abs_b : b;
        end else if (busy_reg) begin
            if (div_reg) begin
                // restoring step: remainder in acc, quotient shifts into x
                if (!rem_diff[DW]) begin
                    acc_next = rem_diff[DW-1:0];
                    x_next   = {x_reg[DW-2:0], 1'b1};
                end else begin
                    acc_next = rem_sh[DW-1:0];
                    x_next   = {x_reg[DW-2:0], 1'b0};
                end
            end else begin
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[DW-2:0], 1'b0};
                y_next = {1'b0, y_reg[DW-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~x_reg + 1'b1) : x_reg) : acc_reg;

endmodule

// ----- rtl/smte_datapath.sv -----
// Datapath: stack RAM, cached top entry, depth, program index, output register.
// Depends on smte_pkg, smte_ram and smte_muldiv.
module smte_datapath
    import smte_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int DATA_WIDTH  = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [S_TDATA_W-1:0] in_data,
    output logic [M_TDATA_W-1:0] out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [MODE_W-1:0]     mode_reg;
    logic [OPERAND_W-1:0]  opnd_reg;
    logic [DATA_WIDTH-1:0] tos_reg, tos_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [INDEX_BITS-1:0] pc_reg, pc_next;
    logic [M_TDATA_W-1:0]  out_reg;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;
    logic [DATA_WIDTH-1:0] opnd_d, cmp_res, r_val;
    logic [DATA_WIDTH-1:0] md_result;
    logic                  md_done;
    logic [CW-1:0]         cnt_m1, cnt_m2, cnt_m3;
    logic [TOP_W-1:0]      top_out;

    assign opnd_d  = opnd_reg[DATA_WIDTH-1:0];
    assign cmp_res = (tos_reg == opnd_d) ? DATA_WIDTH'(1) : '0;
    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_m2  = count_reg - CW'(2);
    assign cnt_m3  = count_reg - CW'(3);

    always_comb begin
        case (mode_reg)
            MODE_ADD: r_val = tos_reg + rdata;
            MODE_SUB: r_val = tos_reg - rdata;
            default:  r_val = md_result;
        endcase
    end

    smte_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    smte_muldiv #(.DW(DATA_WIDTH)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .is_div  (mode_reg == MODE_DIV),
        .a       (tos_reg),
        .b       (rdata),
        .done    (md_done),
        .result  (md_result)
    );

    assign raddr = cmd.rd_third ? cnt_m3[AW-1:0] : cnt_m2[AW-1:0];

    always_comb begin
        we         = 1'b0;
        waddr      = count_reg[AW-1:0];
        wdata      = opnd_d;
        tos_next   = tos_reg;
        count_next = count_reg;
        pc_next    = pc_reg;
        if (cmd.do_push) begin
            we         = 1'b1;
            tos_next   = opnd_d;
            count_next = count_reg + CW'(1);
        end
        if (cmd.do_cmp) begin
            we       = 1'b1;
            waddr    = cnt_m1[AW-1:0];
            wdata    = cmp_res;
            tos_next = cmp_res;
        end
        if (cmd.do_wr_r) begin
            we         = 1'b1;
            waddr      = cnt_m2[AW-1:0];
            wdata      = r_val;
            tos_next   = r_val;
            count_next = cnt_m1;
        end
        if (cmd.do_pop2) begin
            count_next = cnt_m2;
        end
        if (cmd.load_third) begin
            tos_next = rdata;
        end
        if (cmd.do_jump) begin
            pc_next = opnd_reg[INDEX_BITS-1:0];
        end else if (cmd.do_adv) begin
            pc_next = pc_reg + INDEX_BITS'(1);
        end
    end

    assign top_out = (count_reg != '0) ? TOP_W'(signed'(tos_reg)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pc_reg    <= '0;
        end else begin
            count_reg <= count_next;
            pc_reg    <= pc_next;
        end
        tos_reg <= tos_next;
        if (cmd.load_in) begin
            mode_reg <= in_data[MODE_W-1:0];
            opnd_reg <= in_data[MODE_W +: OPERAND_W];
        end
        if (cmd.load_out) begin
            out_reg <= {2'b00, cmd.status, NEXT_W'(pc_reg), DEPTH_W'(count_reg), top_out};
        end
    end

    assign out_data = out_reg;

    assign sts.mode    = mode_reg;
    assign sts.cnt_ge1 = count_reg >= CW'(1);
    assign sts.cnt_ge2 = count_reg >= CW'(2);
    assign sts.cnt_ge3 = count_reg >= CW'(3);
    assign sts.full    = count_reg == CW'(STACK_DEPTH);
    assign sts.b_zero  = rdata == '0;
    assign sts.eq_ab   = tos_reg == rdata;
    assign sts.md_done = md_done;

endmodule

// ----- rtl/smte_ctrl.sv -----
// Controller: token sequencing, error checks and stream handshakes.
// Depends on smte_pkg.
module smte_ctrl
    import smte_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_MD     = 3'd3;
    localparam logic [2:0] S_READ3  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                mvalid_reg, mvalid_next;
    logic                out_free;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd         = '0;
        cmd.status  = status_reg;
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (sts.mode)
                    MODE_PUSH: begin
                        if (sts.full) begin
                            status_next = ST_OVER;
                        end else begin
                            cmd.do_push = 1'b1;
                            cmd.do_adv  = 1'b1;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_JEQ: begin
                        if (!sts.cnt_ge2) begin
                            status_next = ST_UNDER;
                        end else begin
                            cmd.rd_second = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    MODE_JUMP: cmd.do_jump = 1'b1;
                    MODE_CMP: begin
                        if (!sts.cnt_ge1) begin
                            status_next = ST_UNDER;
                        end else begin
                            cmd.do_cmp = 1'b1;
                            cmd.do_adv = 1'b1;
                        end
                    end
                    default: status_next = ST_INVALID;
                endcase
            end
            S_READ: begin
                state_next = S_DONE;
                if (sts.mode inside {MODE_ADD, MODE_SUB}) begin
                    cmd.do_wr_r = 1'b1;
                    cmd.do_adv  = 1'b1;
                end else if (sts.mode == MODE_JEQ) begin
                    cmd.do_jump = sts.eq_ab;
                    cmd.do_adv  = !sts.eq_ab;
                    cmd.do_pop2 = 1'b1;
                    // new top sits three below the old count
                    if (sts.cnt_ge3) begin
                        cmd.rd_third = 1'b1;
                        state_next   = S_READ3;
                    end
                end else if (sts.mode == MODE_DIV && sts.b_zero) begin
                    status_next = ST_DIVZERO;
                end else begin
                    cmd.md_start = 1'b1;
                    state_next   = S_MD;
                end
            end
            S_MD: begin
                if (sts.md_done) begin
                    cmd.do_wr_r = 1'b1;
                    cmd.do_adv  = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_READ3: begin
                cmd.load_third = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.load_out) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

// ----- rtl/smte_checker.sv -----
// Port-level checks on the token executor, attached by bind.
// Depends on smte_pkg and stack_machine_token_executor_defines.svh.
`include "stack_machine_token_executor_defines.svh"

module smte_checker
    import smte_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [DEPTH_W-1:0]  dep;

    assign st  = m_tdata[93:91];
    assign dep = m_tdata[74:64];

    // one token in flight: busy right after an accept
    `SMTE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `SMTE_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `SMTE_ASSERT_NOW(a_over_full, aclk, aresetn, m_tvalid && st == ST_OVER, dep == DEPTH_W'(STACK_DEPTH), "overflow on non-full stack")
    `SMTE_ASSERT_NOW(a_under_short, aclk, aresetn, m_tvalid && st == ST_UNDER, dep < DEPTH_W'(2), "underflow with two or more entries")

endmodule

bind stack_machine_token_executor smte_checker #(.STACK_DEPTH(STACK_DEPTH)) u_smte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb_stack_machine_token_executor.sv -----
// Self-checking testbench for stack_machine_token_executor.
// Drives token items on the s_ stream, predicts each result and checks it on m_.
// Depends on smte_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_stack_machine_token_executor;
    import smte_pkg::*;

    localparam int STACK_DEPTH = 1024;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NEXT_W-1:0]   next_index;
        logic [DEPTH_W-1:0]  depth;
        logic [TOP_W-1:0]    top_value;
    } result_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class token_scoreboard;
        logic [63:0] stack_mem[STACK_DEPTH];
        int unsigned depth_q;
        logic [15:0] pc = '0;
        result_t     pending[$];

        function void note_token(logic [3:0] mode, logic [63:0] opnd);
            result_t r;
            logic [2:0] st;
            logic [15:0] nxt;
            logic [63:0] a, b, ua, ub, q;
            st = ST_OK;
            nxt = pc + 16'd1;
            case (mode)
                MODE_PUSH: begin
                    if (depth_q >= STACK_DEPTH) st = ST_OVER;
                    else begin
                        stack_mem[depth_q] = opnd;
                        depth_q++;
                    end
                end
                MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                    if (depth_q < 2) st = ST_UNDER;
                    else begin
                        a = stack_mem[depth_q-1];
                        b = stack_mem[depth_q-2];
                        if (mode == MODE_DIV && b == 0) st = ST_DIVZERO;
                        else begin
                            if (mode == MODE_ADD) q = a + b;
                            else if (mode == MODE_SUB) q = a - b;
                            else if (mode == MODE_MUL) q = a * b;
                            else begin
                                ua = a[63] ? -a : a;
                                ub = b[63] ? -b : b;
                                q = ua / ub;
                                if (a[63] != b[63]) q = -q;
                            end
                            stack_mem[depth_q-2] = q;
                            depth_q--;
                        end
                    end
                end
                MODE_JUMP: nxt = opnd[15:0];
                MODE_CMP: begin
                    if (depth_q < 1) st = ST_UNDER;
                    else stack_mem[depth_q-1] = (stack_mem[depth_q-1] == opnd) ? 64'd1 : 64'd0;
                end
                MODE_JEQ: begin
                    if (depth_q < 2) st = ST_UNDER;
                    else begin
                        if (stack_mem[depth_q-1] == stack_mem[depth_q-2]) nxt = opnd[15:0];
                        depth_q -= 2;
                    end
                end
                default: st = ST_INVALID;
            endcase
            if (st == ST_OK) pc = nxt;
            r.top_value = depth_q != 0 ? stack_mem[depth_q-1] : 64'd0;
            r.depth = depth_q[DEPTH_W-1:0];
            r.next_index = pc;
            r.status = st;
            pending.push_back(r);
        endfunction

        task check_result(logic [M_TDATA_W-1:0] data);
            result_t got, want;
            got = data[$bits(result_t)-1:0];
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", data[63:0], 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.top_value !== want.top_value)
                report_mismatch("top_value", got.top_value, want.top_value);
            if (got.depth !== want.depth) report_mismatch("depth", got.depth, want.depth);
            if (got.next_index !== want.next_index)
                report_mismatch("next_index", got.next_index, want.next_index);
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    token_scoreboard sb = new();
    int send_idle_pct = 20;
    int recv_idle_pct = 80;
    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;

    stack_machine_token_executor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up after an accept; the next call or an idle cycle replaces it
    task automatic send_token(input logic [3:0] mode, input logic [63:0] opnd);
        if (sent_count == 420) begin send_idle_pct = 80; recv_idle_pct = 20; end
        if (sent_count == 840) begin send_idle_pct = 0; recv_idle_pct = 0; end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, opnd, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_token(mode, opnd);
        sent_count++;
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'hffff_ffff_ffff_ffff;
            2: v = 64'(int'($urandom_range(6)) - 3);
            3: v = 64'h7fff_ffff_ffff_ffff;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_token();
        int pick;
        logic [3:0] mode;
        pick = $urandom_range(99);
        if (pick < 35 && sb.depth_q < STACK_DEPTH) mode = MODE_PUSH;
        else if (pick < 88) mode = 4'($urandom_range(MODE_JEQ, MODE_ADD));
        else if (pick < 95) mode = MODE_PUSH;
        else mode = ($urandom_range(1)) ? 4'd0 : 4'($urandom_range(15, 9));
        send_token(mode, rand_value());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: underflows on empty stack, invalid codes, extremes, div cases
        send_token(MODE_ADD, 64'd0);
        send_token(MODE_CMP, 64'd0);
        send_token(MODE_JEQ, 64'd5);
        send_token(4'd0, 64'd0);
        send_token(4'd15, 64'hffff_ffff_ffff_ffff);
        send_token(MODE_JUMP, 64'hffff_ffff_ffff_ffff);
        send_token(MODE_PUSH, 64'hffff_ffff_ffff_ffff);
        send_token(MODE_PUSH, 64'h8000_0000_0000_0000);
        send_token(MODE_DIV, 64'd0);                     // most negative / -1
        send_token(MODE_PUSH, 64'd0);
        send_token(MODE_PUSH, 64'd5);
        send_token(MODE_DIV, 64'd0);                     // divide by zero
        send_token(MODE_SUB, 64'd0);
        send_token(MODE_PUSH, 64'h7fff_ffff_ffff_ffff);
        send_token(MODE_MUL, 64'd0);
        send_token(MODE_CMP, 64'h8000_0000_0000_0000);
        send_token(MODE_PUSH, 64'd7);
        send_token(MODE_PUSH, 64'd7);
        send_token(MODE_JEQ, 64'h0000_0000_0001_1234);   // taken
        send_token(MODE_PUSH, 64'd1);
        send_token(MODE_PUSH, 64'd2);
        send_token(MODE_JEQ, 64'd99);                    // not taken
        // fill to full and overflow once
        while (sb.depth_q < STACK_DEPTH) send_token(MODE_PUSH, rand_value());
        send_token(MODE_PUSH, 64'd3);
        for (int i = 0; i < 200; i++) begin
            random_token();
        end
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end
endmodule
